// ===== sv/assert_macros.svh =====
// Assertion macros shared by the slab subtraction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked by clk, switched off while rst is high.
`define BDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that a condition never occurs.
`define BDS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/bds_pkg.sv =====
// Types and constants shared by the box subtraction modules.
package bds_pkg;

  // Width of every coordinate port.
  localparam int FIELD_BITS = 16;
  // Width of the volume product of three extents.
  localparam int VOL_BITS   = 3 * FIELD_BITS;
  localparam int DXDY_BITS  = 2 * FIELD_BITS;
  localparam int NUM_SIDES  = 6;

  // Result queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef logic [FIELD_BITS-1:0] coord_t;
  typedef logic [NUM_SIDES-1:0]  side_mask_t;

  typedef enum logic [2:0] {
    SIDE_LEFT   = 3'd0,
    SIDE_RIGHT  = 3'd1,
    SIDE_BACK   = 3'd2,
    SIDE_FRONT  = 3'd3,
    SIDE_BOTTOM = 3'd4,
    SIDE_TOP    = 3'd5
  } side_t;

  // A classified transaction: kept box, clamped cut and the slabs it needs.
  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    coord_t [2:0] cl;
    coord_t [2:0] ch;
    side_mask_t   mask;
  } item_t;

  // One result slab.
  typedef struct packed {
    coord_t               x_lo;
    coord_t               y_lo;
    coord_t               z_lo;
    coord_t               x_hi;
    coord_t               y_hi;
    coord_t               z_hi;
    logic [VOL_BITS-1:0]  volume;
    side_t                side;
    logic                 last;
  } slab_t;

endpackage

// ===== sv/bds_front.sv =====
// Front end: accepts box pairs, clamps the cut box and queues classified items.
`include "assert_macros.svh"

module bds_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  bds_pkg::coord_t [2:0]   keep_lo,
  input  bds_pkg::coord_t [2:0]   keep_hi,
  input  bds_pkg::coord_t [2:0]   cut_lo,
  input  bds_pkg::coord_t [2:0]   cut_hi,
  output logic                    head_valid,
  output bds_pkg::item_t          head,
  input  logic                    head_pop
);
  import bds_pkg::*;

  // Only the low bits of each coordinate take part.
  localparam int CW          = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int MID_DEPTH   = 2;
  localparam int MID_PTR_W   = 1;
  localparam int MID_CNT_W   = 2;

  coord_t [2:0] lo_m, hi_m, cl_m, ch_m, hi_f;
  item_t        item;
  logic         xok, yok;
  logic         wr_en;

  item_t                mid_mem [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr;
  logic [MID_PTR_W-1:0] rd_ptr;
  logic [MID_CNT_W-1:0] count;
  logic [MID_CNT_W-1:0] count_next;

  // Mask, repair inverted boxes and clamp the cut into the kept box per axis.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_m[a] = coord_t'(keep_lo[a][CW-1:0]);
      hi_m[a] = coord_t'(keep_hi[a][CW-1:0]);
      cl_m[a] = coord_t'(cut_lo[a][CW-1:0]);
      ch_m[a] = coord_t'(cut_hi[a][CW-1:0]);
      hi_f[a] = (hi_m[a] < lo_m[a]) ? lo_m[a] : hi_m[a];
      item.lo[a] = lo_m[a];
      item.hi[a] = hi_f[a];
      if (ch_m[a] < cl_m[a]) begin
        // An empty cut on this axis removes nothing.
        item.cl[a] = hi_f[a];
        item.ch[a] = hi_f[a];
      end else begin
        item.cl[a] = (cl_m[a] < lo_m[a]) ? lo_m[a] :
                     (cl_m[a] > hi_f[a]) ? hi_f[a] : cl_m[a];
        item.ch[a] = (ch_m[a] < lo_m[a]) ? lo_m[a] :
                     (ch_m[a] > hi_f[a]) ? hi_f[a] : ch_m[a];
      end
    end
    // Decide which of the six slabs this transaction produces.
    xok = item.ch[0] > item.cl[0];
    yok = item.ch[1] > item.cl[1];
    item.mask[SIDE_LEFT]   = item.cl[0] > item.lo[0];
    item.mask[SIDE_RIGHT]  = item.ch[0] < item.hi[0];
    item.mask[SIDE_BACK]   = (item.cl[1] > item.lo[1]) && xok;
    item.mask[SIDE_FRONT]  = (item.ch[1] < item.hi[1]) && xok;
    item.mask[SIDE_BOTTOM] = (item.cl[2] > item.lo[2]) && xok && yok;
    item.mask[SIDE_TOP]    = (item.ch[2] < item.hi[2]) && xok && yok;
  end

  // Items that produce no slab are accepted and dropped here.
  assign full       = (count == MID_CNT_W'(MID_DEPTH));
  assign wr_en      = push && !full && (item.mask != '0);
  assign head_valid = (count != '0);
  assign head       = mid_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !head_pop) begin
      count_next = count + 1'b1;
    end else if (!wr_en && head_pop) begin
      count_next = count - 1'b1;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (head_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mid_mem[wr_ptr] <= item;
    end
  end

  `BDS_ASSERT(a_pop_has_item, head_pop |-> count != '0, "back end popped an empty item queue")

endmodule

// ===== sv/bds_back.sv =====
// Back end: walks the slabs of the head item and computes corners and volume.
`include "assert_macros.svh"

module bds_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  bds_pkg::item_t                    head,
  output logic                              head_pop,
  input  logic [bds_pkg::OQ_CNT_W-1:0]      oq_count,
  output logic                              oq_wr_en,
  output bds_pkg::slab_t                    oq_wr_slab
);
  import bds_pkg::*;

  side_mask_t            done;
  side_mask_t            remaining;
  side_mask_t            sel;
  logic [2:0]            idx;
  logic                  last;
  logic [OQ_CNT_W-1:0]   level;
  logic                  issue;
  slab_t                 slab_c;

  logic                  s1_valid;
  slab_t                 s1_slab;
  logic                  s2_valid;
  slab_t                 s2_slab;
  logic [DXDY_BITS-1:0]  s2_dxdy;
  coord_t                s2_dz;

  // Pick the lowest slab of the head item that is not yet issued.
  always_comb begin
    remaining = head_valid ? (head.mask & ~done) : '0;
    sel       = remaining & (~remaining + 1'b1);
    idx       = '0;
    for (int i = NUM_SIDES - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        idx = 3'(i);
      end
    end
    last = (remaining & ~sel) == '0;
  end

  // Issue only while the result queue has room for everything in flight.
  assign level    = oq_count + OQ_CNT_W'(s1_valid) + OQ_CNT_W'(s2_valid);
  assign issue    = head_valid && (level < OQ_CNT_W'(OQ_DEPTH));
  assign head_pop = issue && last;

  // Corners of the selected slab.
  always_comb begin
    slab_c        = '0;
    slab_c.side   = side_t'(idx);
    slab_c.last   = last;
    slab_c.x_lo   = head.cl[0];
    slab_c.x_hi   = head.ch[0];
    slab_c.y_lo   = head.lo[1];
    slab_c.y_hi   = head.hi[1];
    slab_c.z_lo   = head.lo[2];
    slab_c.z_hi   = head.hi[2];
    unique case (slab_c.side)
      SIDE_LEFT: begin
        slab_c.x_lo = head.lo[0];
        slab_c.x_hi = head.cl[0];
      end
      SIDE_RIGHT: begin
        slab_c.x_lo = head.ch[0];
        slab_c.x_hi = head.hi[0];
      end
      SIDE_BACK: begin
        slab_c.y_hi = head.cl[1];
      end
      SIDE_FRONT: begin
        slab_c.y_lo = head.ch[1];
      end
      SIDE_BOTTOM: begin
        slab_c.y_lo = head.cl[1];
        slab_c.y_hi = head.ch[1];
        slab_c.z_hi = head.cl[2];
      end
      SIDE_TOP: begin
        slab_c.y_lo = head.cl[1];
        slab_c.y_hi = head.ch[1];
        slab_c.z_lo = head.ch[2];
      end
      default: begin
        slab_c.x_lo = '0;
        slab_c.x_hi = '0;
      end
    endcase
  end

  // Issue progress over the head item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (issue) begin
      done <= last ? '0 : (done | sel);
    end
  end

  // Valid bits of the two arithmetic stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // Stage one holds corners; stage two holds the x by y area and the z extent.
  always_ff @(posedge clk) begin
    s1_slab <= slab_c;
    s2_slab <= s1_slab;
    s2_dxdy <= DXDY_BITS'(s1_slab.x_hi - s1_slab.x_lo) *
               DXDY_BITS'(s1_slab.y_hi - s1_slab.y_lo);
    s2_dz   <= s1_slab.z_hi - s1_slab.z_lo;
  end

  // Final product goes straight into the result queue register.
  always_comb begin
    oq_wr_slab        = s2_slab;
    oq_wr_slab.volume = VOL_BITS'(s2_dxdy) * VOL_BITS'(s2_dz);
  end
  assign oq_wr_en = s2_valid;

  `BDS_ASSERT(a_credit_bound, level <= OQ_CNT_W'(OQ_DEPTH), "slabs in flight exceed queue room")
  `BDS_ASSERT(a_done_idle, !head_valid |-> done == '0, "issue progress left without a head item")

endmodule

// ===== sv/bds_outq.sv =====
// Result queue: holds finished slabs until the receiver pops them.
`include "assert_macros.svh"

module bds_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  bds_pkg::slab_t                wr_slab,
  input  logic                          pop,
  output logic                          empty,
  output bds_pkg::slab_t                rd_slab,
  output logic [bds_pkg::OQ_CNT_W-1:0]  count
);
  import bds_pkg::*;

  slab_t               mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic                rd_en;
  logic [OQ_CNT_W-1:0] count_next;

  assign empty   = (count == '0);
  assign rd_en   = pop && !empty;
  assign rd_slab = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_next = count - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Slab storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_slab;
    end
  end

  `BDS_ASSERT_NEVER(a_no_overflow, wr_en && count == OQ_CNT_W'(OQ_DEPTH), "result queue overflow")

endmodule

// ===== sv/box_difference_slabs.sv =====
// Top level of the box subtraction block: kept box minus cut box as slabs.
//
// Input channel: a transaction carries a kept box and a cut box; it is taken
// on a clock edge with push high and full low. Up to two classified
// transactions wait between the front end and the slab sequencer.
// Result channel: while empty is low the oldest slab is on the slab ports;
// it leaves on an edge with pop high. Slabs of one transaction come in the
// order left, right, back, front, bottom, top, and the final one has
// slab_last set. A transaction that yields no slab produces no result.
// An accepted transaction passes the item queue, corner stage and area
// stage before its first slab is visible. Throughput: one slab per cycle
// while the result queue has room; a transaction gives one to six slabs on
// the single result port; input keeps being accepted while results wait.
// A stalled receiver fills the four-entry result queue, then the item queue,
// and then full rises. Reset empties both queues and the arithmetic stages.
module box_difference_slabs #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [15:0]               keep_x_lo,
  input  logic [15:0]               keep_y_lo,
  input  logic [15:0]               keep_z_lo,
  input  logic [15:0]               keep_x_hi,
  input  logic [15:0]               keep_y_hi,
  input  logic [15:0]               keep_z_hi,
  input  logic [15:0]               cut_x_lo,
  input  logic [15:0]               cut_y_lo,
  input  logic [15:0]               cut_z_lo,
  input  logic [15:0]               cut_x_hi,
  input  logic [15:0]               cut_y_hi,
  input  logic [15:0]               cut_z_hi,
  output logic                      empty,
  input  logic                      pop,
  output logic [15:0]               slab_x_lo,
  output logic [15:0]               slab_y_lo,
  output logic [15:0]               slab_z_lo,
  output logic [15:0]               slab_x_hi,
  output logic [15:0]               slab_y_hi,
  output logic [15:0]               slab_z_hi,
  output logic [47:0]               slab_volume,
  output logic [2:0]                slab_side,
  output logic                      slab_last
);
  import bds_pkg::*;

  coord_t [2:0]        keep_lo, keep_hi, cut_lo, cut_hi;
  logic                head_valid;
  item_t               head;
  logic                head_pop;
  logic [OQ_CNT_W-1:0] oq_count;
  logic                oq_wr_en;
  slab_t               oq_wr_slab;
  slab_t               rd_slab;

  // Gather the box corners by axis.
  assign keep_lo = {keep_z_lo, keep_y_lo, keep_x_lo};
  assign keep_hi = {keep_z_hi, keep_y_hi, keep_x_hi};
  assign cut_lo  = {cut_z_lo, cut_y_lo, cut_x_lo};
  assign cut_hi  = {cut_z_hi, cut_y_hi, cut_x_hi};

  bds_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .keep_lo    (keep_lo),
    .keep_hi    (keep_hi),
    .cut_lo     (cut_lo),
    .cut_hi     (cut_hi),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  bds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .oq_count   (oq_count),
    .oq_wr_en   (oq_wr_en),
    .oq_wr_slab (oq_wr_slab)
  );

  bds_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_wr_en),
    .wr_slab (oq_wr_slab),
    .pop     (pop),
    .empty   (empty),
    .rd_slab (rd_slab),
    .count   (oq_count)
  );

  // Present the oldest slab.
  assign slab_x_lo   = rd_slab.x_lo;
  assign slab_y_lo   = rd_slab.y_lo;
  assign slab_z_lo   = rd_slab.z_lo;
  assign slab_x_hi   = rd_slab.x_hi;
  assign slab_y_hi   = rd_slab.y_hi;
  assign slab_z_hi   = rd_slab.z_hi;
  assign slab_volume = rd_slab.volume;
  assign slab_side   = rd_slab.side;
  assign slab_last   = rd_slab.last;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for box_difference_slabs: directed table, then random box pairs.
module testbench;
  import bds_pkg::*;

  localparam int MAX_CYCLES   = 400000;
  localparam int RANDOM_ITEMS = 130;
  localparam int QUIET_ITEMS  = 25;
  localparam int SETTLE_CYCLES = 16;
  localparam int COORD_MAX    = 65535;
  localparam int MAX_REPORTS  = 10;

  // Per-axis shape of a random box pair.
  typedef enum int {
    SHAPE_OVERLAP,
    SHAPE_DISJOINT,
    SHAPE_NOISE
  } axis_shape_t;

  // One input transaction: index 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    coord_t [2:0] keep_lo;
    coord_t [2:0] keep_hi;
    coord_t [2:0] cut_lo;
    coord_t [2:0] cut_hi;
  } box_pair_t;

  // A directed row; hand_checked rows carry their expected slab (at most one).
  typedef struct packed {
    box_pair_t pair;
    logic      hand_checked;
    logic      one_slab;
    slab_t     slab;
  } box_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [15:0] keep_x_lo = '0;
  logic [15:0] keep_y_lo = '0;
  logic [15:0] keep_z_lo = '0;
  logic [15:0] keep_x_hi = '0;
  logic [15:0] keep_y_hi = '0;
  logic [15:0] keep_z_hi = '0;
  logic [15:0] cut_x_lo = '0;
  logic [15:0] cut_y_lo = '0;
  logic [15:0] cut_z_lo = '0;
  logic [15:0] cut_x_hi = '0;
  logic [15:0] cut_y_hi = '0;
  logic [15:0] cut_z_hi = '0;
  logic [15:0] slab_x_lo;
  logic [15:0] slab_y_lo;
  logic [15:0] slab_z_lo;
  logic [15:0] slab_x_hi;
  logic [15:0] slab_y_hi;
  logic [15:0] slab_z_hi;
  logic [47:0] slab_volume;
  logic [2:0]  slab_side;
  logic        slab_last;

  slab_t    pending_slabs[$];
  box_row_t box_rows[$];
  slab_t    got_slab;
  slab_t    want_slab;
  int       fail_count = 0;
  int       cycle_count = 0;
  int       idle_mode = 0;
  int       pop_hold = 0;

  box_difference_slabs u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .keep_x_lo   (keep_x_lo),
    .keep_y_lo   (keep_y_lo),
    .keep_z_lo   (keep_z_lo),
    .keep_x_hi   (keep_x_hi),
    .keep_y_hi   (keep_y_hi),
    .keep_z_hi   (keep_z_hi),
    .cut_x_lo    (cut_x_lo),
    .cut_y_lo    (cut_y_lo),
    .cut_z_lo    (cut_z_lo),
    .cut_x_hi    (cut_x_hi),
    .cut_y_hi    (cut_y_hi),
    .cut_z_hi    (cut_z_hi),
    .empty       (empty),
    .pop         (pop),
    .slab_x_lo   (slab_x_lo),
    .slab_y_lo   (slab_y_lo),
    .slab_z_lo   (slab_z_lo),
    .slab_x_hi   (slab_x_hi),
    .slab_y_hi   (slab_y_hi),
    .slab_z_hi   (slab_z_hi),
    .slab_volume (slab_volume),
    .slab_side   (slab_side),
    .slab_last   (slab_last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Appends one slab to the expected results.
  function automatic void queue_slab(input slab_t s);
    pending_slabs = {pending_slabs, s};
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input box_row_t r);
    box_rows = {box_rows, r};
  endfunction

  // Builds a slab and its volume, saturated to the volume field.
  function automatic slab_t make_slab(input side_t side, input coord_t xl, input coord_t yl,
                                      input coord_t zl, input coord_t xh, input coord_t yh,
                                      input coord_t zh);
    slab_t       s;
    logic [63:0] vol;
    vol = 64'(xh - xl) * 64'(yh - yl) * 64'(zh - zl);
    if (vol > 64'hFFFF_FFFF_FFFF) begin
      vol = 64'hFFFF_FFFF_FFFF;
    end
    s = '{xl, yl, zl, xh, yh, zh, vol[47:0], side, 1'b0};
    return s;
  endfunction

  // Computes the slabs of kept box minus clamped cut box and queues them.
  function automatic void carve_box(input box_pair_t b);
    coord_t lo[3];
    coord_t hi[3];
    coord_t cl[3];
    coord_t ch[3];
    slab_t  found[$];
    slab_t  tail;
    logic   x_open;
    logic   y_open;
    for (int a = 0; a < 3; a++) begin
      lo[a] = b.keep_lo[a];
      hi[a] = (b.keep_hi[a] < lo[a]) ? lo[a] : b.keep_hi[a];
      // An inverted cut removes nothing on that axis.
      if (b.cut_hi[a] < b.cut_lo[a]) begin
        cl[a] = hi[a];
        ch[a] = hi[a];
      end else begin
        cl[a] = (b.cut_lo[a] < lo[a]) ? lo[a] : (b.cut_lo[a] > hi[a]) ? hi[a] : b.cut_lo[a];
        ch[a] = (b.cut_hi[a] < lo[a]) ? lo[a] : (b.cut_hi[a] > hi[a]) ? hi[a] : b.cut_hi[a];
      end
    end
    x_open = ch[0] > cl[0];
    y_open = ch[1] > cl[1];
    if (cl[0] > lo[0])
      found = {found, make_slab(SIDE_LEFT, lo[0], lo[1], lo[2], cl[0], hi[1], hi[2])};
    if (ch[0] < hi[0])
      found = {found, make_slab(SIDE_RIGHT, ch[0], lo[1], lo[2], hi[0], hi[1], hi[2])};
    if (cl[1] > lo[1] && x_open)
      found = {found, make_slab(SIDE_BACK, cl[0], lo[1], lo[2], ch[0], cl[1], hi[2])};
    if (ch[1] < hi[1] && x_open)
      found = {found, make_slab(SIDE_FRONT, cl[0], ch[1], lo[2], ch[0], hi[1], hi[2])};
    if (cl[2] > lo[2] && x_open && y_open)
      found = {found, make_slab(SIDE_BOTTOM, cl[0], cl[1], lo[2], ch[0], ch[1], cl[2])};
    if (ch[2] < hi[2] && x_open && y_open)
      found = {found, make_slab(SIDE_TOP, cl[0], cl[1], ch[2], ch[0], ch[1], hi[2])};
    if (found.size() > 0) begin
      tail = found[found.size() - 1];
      tail.last = 1'b1;
      found[found.size() - 1] = tail;
    end
    foreach (found[k]) queue_slab(found[k]);
  endfunction

  function automatic box_pair_t mk_pair(input int kxl, input int kyl, input int kzl,
                                        input int kxh, input int kyh, input int kzh,
                                        input int cxl, input int cyl, input int czl,
                                        input int cxh, input int cyh, input int czh);
    box_pair_t b;
    b.keep_lo = {coord_t'(kzl), coord_t'(kyl), coord_t'(kxl)};
    b.keep_hi = {coord_t'(kzh), coord_t'(kyh), coord_t'(kxh)};
    b.cut_lo  = {coord_t'(czl), coord_t'(cyl), coord_t'(cxl)};
    b.cut_hi  = {coord_t'(czh), coord_t'(cyh), coord_t'(cxh)};
    return b;
  endfunction

  // Picks the kept and cut ranges of one axis.
  function automatic void random_axis(input axis_shape_t shape, output coord_t klo,
                                      output coord_t khi, output coord_t clo,
                                      output coord_t chi);
    int a;
    int b;
    int c;
    int d;
    int off;
    a = $urandom_range(COORD_MAX, 0);
    if ($urandom_range(3, 0) == 0) begin
      b = $urandom_range(COORD_MAX, 0);
      if (a > b) begin
        c = a;
        a = b;
        b = c;
      end
    end else begin
      b = a + $urandom_range(40, 0);
      if (b > COORD_MAX) b = COORD_MAX;
    end
    off = (b - a) / 4 + 3;
    case (shape)
      SHAPE_NOISE: begin
        b = $urandom_range(COORD_MAX, 0);
        c = $urandom_range(COORD_MAX, 0);
        d = $urandom_range(COORD_MAX, 0);
      end
      SHAPE_DISJOINT: begin
        if ($urandom_range(1, 0) == 1 || a == 0) begin
          c = b + $urandom_range(30, 0);
          if (c > COORD_MAX) c = COORD_MAX;
          d = c + $urandom_range(30, 0);
          if (d > COORD_MAX) d = COORD_MAX;
        end else begin
          d = a - $urandom_range(30, 1);
          if (d < 0) d = 0;
          c = d - $urandom_range(30, 0);
          if (c < 0) c = 0;
        end
      end
      default: begin
        c = $urandom_range(b, (a > off) ? a - off : 0);
        d = $urandom_range((b + off > COORD_MAX) ? COORD_MAX : b + off, c);
        // Cuts flush with a kept face, and now and then an inverted cut.
        if ($urandom_range(3, 0) == 0) c = a;
        if ($urandom_range(3, 0) == 0) d = b;
        if ($urandom_range(11, 0) == 0) begin
          off = c;
          c = d;
          d = off;
        end
      end
    endcase
    klo = coord_t'(a);
    khi = coord_t'(b);
    clo = coord_t'(c);
    chi = coord_t'(d);
  endfunction

  // Mostly overlapping pairs; some with one disjoint axis, some pure noise.
  function automatic box_pair_t random_pair();
    box_pair_t   b;
    axis_shape_t shape;
    int          kind;
    int          odd_axis;
    coord_t      klo;
    coord_t      khi;
    coord_t      clo;
    coord_t      chi;
    kind = $urandom_range(9, 0);
    odd_axis = $urandom_range(2, 0);
    for (int a = 0; a < 3; a++) begin
      if (kind == 0) shape = SHAPE_NOISE;
      else if (kind == 1 && a == odd_axis) shape = SHAPE_DISJOINT;
      else shape = SHAPE_OVERLAP;
      random_axis(shape, klo, khi, clo, chi);
      b.keep_lo[a] = klo;
      b.keep_hi[a] = khi;
      b.cut_lo[a]  = clo;
      b.cut_hi[a]  = chi;
    end
    return b;
  endfunction

  function automatic string slab_text(input slab_t s);
    return $sformatf("side %0d x %0d..%0d y %0d..%0d z %0d..%0d vol %0d last %0d",
                     s.side, s.x_lo, s.x_hi, s.y_lo, s.y_hi, s.z_lo, s.z_hi,
                     s.volume, s.last);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Presents one transaction and returns at the edge that accepts it.
  task automatic send_pair(input box_pair_t b);
    keep_x_lo <= b.keep_lo[0];
    keep_y_lo <= b.keep_lo[1];
    keep_z_lo <= b.keep_lo[2];
    keep_x_hi <= b.keep_hi[0];
    keep_y_hi <= b.keep_hi[1];
    keep_z_hi <= b.keep_hi[2];
    cut_x_lo  <= b.cut_lo[0];
    cut_y_lo  <= b.cut_lo[1];
    cut_z_lo  <= b.cut_lo[2];
    cut_x_hi  <= b.cut_hi[0];
    cut_y_hi  <= b.cut_hi[1];
    cut_z_hi  <= b.cut_hi[2];
    push      <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Random sender gap, taken more often in idle mode 2 and never in idle mode 0.
  task automatic sender_gap();
    if (idle_mode != 0 && $urandom_range((idle_mode == 1) ? 8 : 2, 0) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // Holds the sender off until every queued slab has come out.
  task automatic drain_slabs();
    push <= 1'b0;
    @(posedge clk);
    while (pending_slabs.size() != 0) @(posedge clk);
  endtask

  // Receiver: pop stalls in random bursts, more often in idle mode 2 and never in idle mode 0.
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (idle_mode != 0 && $urandom_range((idle_mode == 1) ? 12 : 4, 0) == 0) begin
      pop_hold <= $urandom_range(15, 0);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Compares each popped slab with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      got_slab = '{slab_x_lo, slab_y_lo, slab_z_lo, slab_x_hi, slab_y_hi, slab_z_hi,
                   slab_volume, side_t'(slab_side), slab_last};
      if (pending_slabs.size() == 0) begin
        note_failure($sformatf("unexpected slab: %s", slab_text(got_slab)));
      end else begin
        want_slab = pending_slabs.pop_front();
        if (got_slab.x_lo !== want_slab.x_lo || got_slab.y_lo !== want_slab.y_lo ||
            got_slab.z_lo !== want_slab.z_lo || got_slab.x_hi !== want_slab.x_hi ||
            got_slab.y_hi !== want_slab.y_hi || got_slab.z_hi !== want_slab.z_hi ||
            got_slab.volume !== want_slab.volume || got_slab.side !== want_slab.side ||
            got_slab.last !== want_slab.last) begin
          note_failure($sformatf("slab mismatch: expected %s, got %s",
                                 slab_text(want_slab), slab_text(got_slab)));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus: directed table, pause, random transactions, quiet tail, drain.
  initial begin
    box_row_t row;
    box_pair_t pair;

    // Hand-checked rows: whole-range box with an inverted cut, identical boxes,
    // point boxes at both extremes, a disjoint cut and an inverted kept box.
    add_row('{mk_pair(0, 0, 0, 65535, 65535, 65535,
                      65535, 65535, 65535, 0, 0, 0), 1'b1, 1'b1,
              '{16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                48'hFFFD_0002_FFFF, SIDE_LEFT, 1'b1}});
    add_row('{mk_pair(100, 100, 100, 200, 200, 200,
                      100, 100, 100, 200, 200, 200), 1'b1, 1'b0, '0});
    add_row('{mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, '0});
    add_row('{mk_pair(65535, 65535, 65535, 65535, 65535, 65535,
                      65535, 65535, 65535, 65535, 65535, 65535), 1'b1, 1'b0, '0});
    add_row('{mk_pair(10, 10, 10, 20, 20, 20, 30, 30, 30, 40, 40, 40), 1'b1, 1'b1,
              '{16'd10, 16'd10, 16'd10, 16'd20, 16'd20, 16'd20,
                48'd1000, SIDE_LEFT, 1'b1}});
    add_row('{mk_pair(50, 0, 0, 40, 10, 10, 0, 0, 0, 5, 10, 10), 1'b1, 1'b0, '0});

    // Predicted rows: all six sides, each face flush, huge extents, full cover,
    // inverted cut on one axis, flat boxes and bit patterns.
    add_row('{mk_pair(100, 100, 100, 200, 200, 200,
                      120, 120, 120, 180, 180, 180), 1'b0, 1'b0, '0});
    add_row('{mk_pair(100, 100, 100, 200, 200, 200,
                      100, 120, 120, 180, 180, 180), 1'b0, 1'b0, '0});
    add_row('{mk_pair(100, 100, 100, 200, 200, 200,
                      120, 120, 120, 200, 180, 180), 1'b0, 1'b0, '0});
    add_row('{mk_pair(100, 100, 100, 200, 200, 200,
                      120, 100, 120, 180, 180, 180), 1'b0, 1'b0, '0});
    add_row('{mk_pair(100, 100, 100, 200, 200, 200,
                      120, 120, 120, 180, 180, 200), 1'b0, 1'b0, '0});
    add_row('{mk_pair(0, 0, 0, 65535, 65535, 65535,
                      1, 1, 1, 65534, 65534, 65534), 1'b0, 1'b0, '0});
    add_row('{mk_pair(1000, 1000, 1000, 2000, 2000, 2000,
                      0, 0, 0, 65535, 65535, 65535), 1'b0, 1'b0, '0});
    add_row('{mk_pair(0, 0, 0, 100, 100, 100, 10, 50, 10, 90, 40, 90),
              1'b0, 1'b0, '0});
    add_row('{mk_pair(10, 10, 10, 20, 10, 20, 12, 10, 12, 18, 10, 18),
              1'b0, 1'b0, '0});
    add_row('{mk_pair(300, 0, 0, 200, 50, 50, 250, 10, 10, 260, 20, 20),
              1'b0, 1'b0, '0});
    add_row('{mk_pair(16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                      16'h6666, 16'h6666, 16'h6666, 16'h9999, 16'h9999, 16'h9999),
              1'b0, 1'b0, '0});
    add_row('{mk_pair(0, 0, 0, 100, 100, 100, 200, 20, 20, 300, 80, 80),
              1'b0, 1'b0, '0});
    add_row('{mk_pair(500, 500, 500, 600, 600, 600, 520, 520, 0, 580, 580, 550),
              1'b0, 1'b0, '0});
    add_row('{mk_pair(0, 0, 0, 100, 100, 100, 0, 30, 0, 100, 60, 100),
              1'b0, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part with heavy idling on both sides.
    idle_mode = 2;
    foreach (box_rows[r]) begin
      row = box_rows[r];
      send_pair(row.pair);
      if (row.hand_checked) begin
        if (row.one_slab) queue_slab(row.slab);
      end else begin
        carve_box(row.pair);
      end
      sender_gap();
    end
    drain_slabs();

    // Random part: idle modes rotate in stretches, the tail runs without gaps.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_mode = (i >= RANDOM_ITEMS - QUIET_ITEMS) ? 0 : (i / 20) % 3;
      pair = random_pair();
      send_pair(pair);
      carve_box(pair);
      sender_gap();
      if (i == RANDOM_ITEMS / 2) drain_slabs();
    end

    // Wait out the last slabs, then give stray results time to show up.
    drain_slabs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_slabs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
